[design/lvp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_pkg: shared types, constants and cosine table builder
// Q16 cosine table for angle gaps of 0..90.0 degrees and common widths.
// ----------------------------------------------------------------------------
package lvp_pkg;

	localparam int COS_W     = 17;             // Q16, 65536 = 1.0
	localparam int COS_DEPTH = 901;            // 0..900 tenths of a degree
	localparam int COS_AW    = 10;
	localparam int ANG_W     = 16;
	localparam int LINE_W    = 17;
	localparam logic [LINE_W-1:0] LINE_MAX = 17'h1FFFF;
	localparam logic [10:0] GAP_HALF = 11'd1800;   // 180.0 degrees
	localparam logic [11:0] GAP_FULL = 12'd3600;   // 360.0 degrees
	localparam logic [10:0] GAP_QTR  = 11'd900;    // 90.0 degrees
	localparam longint unsigned PI_Q28 = 64'd843314857;

	typedef logic [COS_W-1:0] cos_tab_t [0:COS_DEPTH-1];

	// Taylor series of the cosine in Q28, rounded to Q16
	function automatic logic [COS_W-1:0] cos_q16(input int unsigned e);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned t;
		longint          sum;
		longint unsigned c;
		x    = (longint'(e) * PI_Q28) / 1800;
		x2   = (x * x) >> 28;
		term = 64'd1 << 28;
		sum  = 64'sd1 << 28;
		for (int k = 1; k <= 10; k++) begin
			t = (term * x2) >> 28;
			// divisor is (2k-1)*2k
			case (k)
				1: term = t / 2;
				2: term = t / 12;
				3: term = t / 30;
				4: term = t / 56;
				5: term = t / 90;
				6: term = t / 132;
				7: term = t / 182;
				8: term = t / 240;
				9: term = t / 306;
				default: term = t / 380;
			endcase
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		c = (longint'(sum) + 2048) >> 12;
		return c[COS_W-1:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		for (int i = 0; i < COS_DEPTH; i++)
			t[i] = cos_q16(i);
		return t;
	endfunction

endpackage

[design/line_voltage_from_phases.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_voltage_from_phases: line-to-line voltages from phase data
// Three parallel lanes compute A-B, B-C and C-A by the law of cosines.
// ----------------------------------------------------------------------------
// Usage: drive the six phase fields and pulse start; busy is always low, so an
// item can be started every cycle. Each item yields one result on line_ab,
// line_bc and line_ca, marked by a one-cycle done pulse. There is no way to
// stall the result; capture it on done. The latency is set by the front end
// (gap fold, cosine ROM read, products, cosine term, radicand), a square-root
// pipeline that resolves one result bit per stage, and the merge register.
// ----------------------------------------------------------------------------
module line_voltage_from_phases #(
	parameter int VOLT_MAX = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] phase_a_raw,
	input  logic [31:0] phase_b_raw,
	input  logic [31:0] phase_c_raw,
	input  logic signed [15:0] angle_a_raw,
	input  logic signed [15:0] angle_b_raw,
	input  logic signed [15:0] angle_c_raw,
	output logic        done,
	output logic [16:0] line_ab,
	output logic [16:0] line_bc,
	output logic [16:0] line_ca
);

	// voltage width and pipeline depth follow from the saturation limit
	localparam int VW       = $clog2(VOLT_MAX + 1);
	localparam int RW       = VW + 1;
	localparam int LANE_LAT = 5 + RW;
	localparam int OUT_LAT  = LANE_LAT + 1;
	localparam int XW       = (RW > lvp_pkg::LINE_W) ? RW : lvp_pkg::LINE_W;
	localparam logic [31:0] VMAX32 = 32'(VOLT_MAX);

	// pipeline never stalls
	assign busy = 1'b0;

	// voltage decode: all ones reads as zero, large values saturate
	function automatic logic [VW-1:0] volt_dec(input logic [31:0] raw);
		if (raw == 32'hFFFF_FFFF)
			return '0;
		else if (raw > VMAX32)
			return VMAX32[VW-1:0];
		else
			return raw[VW-1:0];
	endfunction

	// angle decode: minus one reads as zero
	function automatic logic signed [15:0] ang_dec(input logic signed [15:0] raw);
		return (raw == 16'hFFFF) ? 16'sd0 : raw;
	endfunction

	logic [VW-1:0]      ua, ub, uc;
	logic signed [15:0] fa, fb, fc;

	assign ua = volt_dec(phase_a_raw);
	assign ub = volt_dec(phase_b_raw);
	assign uc = volt_dec(phase_c_raw);
	assign fa = ang_dec(angle_a_raw);
	assign fb = ang_dec(angle_b_raw);
	assign fc = ang_dec(angle_c_raw);

	// three lanes, one per line pair
	logic [RW-1:0] root_ab, root_bc, root_ca;

	lvp_lane #(.VW(VW)) u_lane_ab (
		.clk (clk), .volt_p (ua), .volt_q (ub), .ang_p (fa), .ang_q (fb),
		.root (root_ab)
	);

	lvp_lane #(.VW(VW)) u_lane_bc (
		.clk (clk), .volt_p (ub), .volt_q (uc), .ang_p (fb), .ang_q (fc),
		.root (root_bc)
	);

	lvp_lane #(.VW(VW)) u_lane_ca (
		.clk (clk), .volt_p (uc), .volt_q (ua), .ang_p (fc), .ang_q (fa),
		.root (root_ca)
	);

	// item tracking: lanes have equal fixed latency
	logic [OUT_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[OUT_LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[OUT_LAT-1];

	// merge stage: saturate and register all three lines together
	function automatic logic [16:0] sat_line(input logic [RW-1:0] r);
		logic [XW-1:0] rx;
		rx = XW'(r);
		if (rx > XW'(lvp_pkg::LINE_MAX))
			return lvp_pkg::LINE_MAX;
		else
			return rx[16:0];
	endfunction

	always_ff @(posedge clk) begin
		line_ab <= sat_line(root_ab);
		line_bc <= sat_line(root_bc);
		line_ca <= sat_line(root_ca);
	end

`ifndef SYNTHESIS
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("done without a started item");

	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##OUT_LAT done)
		else $error("started item produced no result");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("start refused");
`endif

endmodule

[design/lvp_cos_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_cos_rom: cosine lookup, registered read
// Magnitude of the Q16 cosine for a gap folded into 0..90.0 degrees.
// ----------------------------------------------------------------------------
module lvp_cos_rom (
	input  logic                         clk,
	input  logic [lvp_pkg::COS_AW-1:0]   addr,
	output logic [lvp_pkg::COS_W-1:0]    data
);

	localparam lvp_pkg::cos_tab_t COS_TAB = lvp_pkg::build_cos_tab();

	always_ff @(posedge clk) begin
		data <= COS_TAB[addr];
	end

endmodule

[design/lvp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_isqrt: pipelined integer square root
// One result bit per stage, restoring method.
// ----------------------------------------------------------------------------
module lvp_isqrt #(
	parameter int FW = 34
) (
	input  logic            clk,
	input  logic [FW-1:0]   radicand,
	output logic [FW/2-1:0] root
);

	localparam int RW = FW / 2;

	logic [FW-1:0] rem_sn [0:RW];
	logic [RW-1:0] res_sn [0:RW];

	assign rem_sn[0] = radicand;
	assign res_sn[0] = '0;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int B = RW - 1 - i;
		logic [FW:0] trial;
		assign trial = ({{(FW+1-RW){1'b0}}, res_sn[i]} << (B + 1))
			| ((FW+1)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if ({1'b0, rem_sn[i]} >= trial) begin
				rem_sn[i+1] <= rem_sn[i] - trial[FW-1:0];
				res_sn[i+1] <= res_sn[i] | (RW'(1) << B);
			end else begin
				rem_sn[i+1] <= rem_sn[i];
				res_sn[i+1] <= res_sn[i];
			end
		end
	end

	assign root = res_sn[RW];

endmodule

[design/lvp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_lane: one line voltage by the law of cosines
// Angle gap, cosine lookup, products, f = a^2 + b^2 - 2ab*cos, square root.
// ----------------------------------------------------------------------------
module lvp_lane #(
	parameter int VW = 16
) (
	input  logic                           clk,
	input  logic [VW-1:0]                  volt_p,
	input  logic [VW-1:0]                  volt_q,
	input  logic signed [lvp_pkg::ANG_W-1:0] ang_p,
	input  logic signed [lvp_pkg::ANG_W-1:0] ang_q,
	output logic [VW:0]                    root
);

	localparam int FW = 2 * VW + 2;
	localparam int PW = VW + lvp_pkg::COS_W;
	localparam int MW = 2 * VW + lvp_pkg::COS_W;

	// gap folding
	logic signed [lvp_pkg::ANG_W:0] diff;
	logic [lvp_pkg::ANG_W:0]        mag;
	logic [10:0]                    gap;
	logic [10:0]                    e_fold;
	logic                           neg_fold;

	always_comb begin
		diff = ang_p - ang_q;
		mag  = diff[lvp_pkg::ANG_W] ? 17'(-diff) : 17'(diff);
		if (mag <= 17'(lvp_pkg::GAP_HALF))
			gap = mag[10:0];
		else if (mag > 17'(lvp_pkg::GAP_FULL))
			gap = '0;
		else
			gap = 11'(17'(lvp_pkg::GAP_FULL) - mag);
		neg_fold = gap > lvp_pkg::GAP_QTR;
		e_fold   = neg_fold ? lvp_pkg::GAP_HALF - gap : gap;
	end

	logic [VW-1:0]                a_s1, b_s1;
	logic [lvp_pkg::COS_AW-1:0]   e_s1;
	logic                         neg_s1;

	always_ff @(posedge clk) begin
		a_s1   <= volt_p;
		b_s1   <= volt_q;
		e_s1   <= e_fold[lvp_pkg::COS_AW-1:0];
		neg_s1 <= neg_fold;
	end

	logic [lvp_pkg::COS_W-1:0] cos_s2;
	logic [2*VW-1:0]           aa_s2, bb_s2, ab_s2;
	logic                      neg_s2;

	lvp_cos_rom u_rom (
		.clk  (clk),
		.addr (e_s1),
		.data (cos_s2)
	);

	always_ff @(posedge clk) begin
		aa_s2  <= a_s1 * a_s1;
		bb_s2  <= b_s1 * b_s1;
		ab_s2  <= a_s1 * b_s1;
		neg_s2 <= neg_s1;
	end

	logic [2*VW:0] sum_s3;
	logic [PW-1:0] pl_s3, ph_s3;
	logic          neg_s3;

	always_ff @(posedge clk) begin
		sum_s3 <= {1'b0, aa_s2} + {1'b0, bb_s2};
		pl_s3  <= ab_s2[VW-1:0] * cos_s2;
		ph_s3  <= ab_s2[2*VW-1:VW] * cos_s2;
		neg_s3 <= neg_s2;
	end

	// q = floor(2*ab*cos / 65536), rounded away from zero when cos < 0
	logic [MW-1:0]    prod;
	logic [MW-1:0]    q_s4;
	logic [2*VW:0]    sum_s4;
	logic             neg_s4;

	assign prod = (MW'(ph_s3) << VW) + MW'(pl_s3);

	always_ff @(posedge clk) begin
		q_s4   <= neg_s3 ? ((prod + MW'(32767)) >> 15) : (prod >> 15);
		sum_s4 <= sum_s3;
		neg_s4 <= neg_s3;
	end

	logic [FW-1:0] q_fw;
	logic [FW-1:0] sum_fw;
	logic [FW-1:0] f_s5;

	assign q_fw   = q_s4[FW-1:0];
	assign sum_fw = FW'(sum_s4);

	always_ff @(posedge clk) begin
		if (neg_s4)
			f_s5 <= sum_fw + q_fw;
		else if (sum_fw >= q_fw)
			f_s5 <= sum_fw - q_fw;
		else
			f_s5 <= '0;
	end

	lvp_isqrt #(.FW(FW)) u_isqrt (
		.clk      (clk),
		.radicand (f_s5),
		.root     (root)
	);

endmodule

[test/line_voltage_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_voltage_checker: predicts and checks the line voltages
// Computes the expected line voltages of every item accepted at start and
// compares them with each result marked by done.
// ----------------------------------------------------------------------------
module line_voltage_checker #(
	parameter int VOLT_MAX = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [31:0]        phase_a_raw,
	input  logic [31:0]        phase_b_raw,
	input  logic [31:0]        phase_c_raw,
	input  logic signed [15:0] angle_a_raw,
	input  logic signed [15:0] angle_b_raw,
	input  logic signed [15:0] angle_c_raw,
	input  logic               done,
	input  logic [16:0]        line_ab,
	input  logic [16:0]        line_bc,
	input  logic [16:0]        line_ca,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [16:0] ab;
		logic [16:0] bc;
		logic [16:0] ca;
	} lines_t;

	lines_t expected_lines[$];
	longint cos_rom[0:1800];

	// Taylor series cosine, Q28 summed, rounded to Q16; mirrored above 90 deg
	function automatic longint cos_of_gap(input int d);
		longint unsigned e;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint c;
		e = (d > 900) ? 1800 - d : d;
		x = (e * 64'd843314857) / 1800;
		x2 = (x * x) >> 28;
		term = 64'd1 << 28;
		sum = 64'sd1 << 28;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >> 28) / ((2 * k - 1) * (2 * k));
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		c = (sum + 2048) >>> 12;
		return (d > 900) ? -c : c;
	endfunction

	function automatic longint volt_val(input logic [31:0] raw);
		if (raw == 32'hFFFF_FFFF)
			return 0;
		if (raw > VOLT_MAX)
			return VOLT_MAX;
		return raw;
	endfunction

	function automatic int angle_val(input logic [15:0] raw);
		if (raw == 16'hFFFF)
			return 0;
		return int'($signed(raw));
	endfunction

	function automatic int fold_gap(input int p, input int q);
		int g;
		g = p - q;
		if (g < 0)
			g = -g;
		if (g > 1800)
			g = 3600 - g;
		if (g < 0)
			g = 0;
		return g;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [16:0] cosine_law(input longint a, input longint b, input int gap);
		longint p;
		longint q;
		longint f;
		longint unsigned r;
		p = 2 * a * b * cos_rom[gap];
		if (p >= 0)
			q = p >>> 16;
		else
			q = -((-p + 65535) >>> 16);
		f = a * a + b * b - q;
		if (f < 0)
			f = 0;
		r = floor_sqrt(f);
		if (r > 131071)
			r = 131071;
		return r[16:0];
	endfunction

	initial begin
		for (int i = 0; i <= 1800; i++)
			cos_rom[i] = cos_of_gap(i);
	end

	assign pending = expected_lines.size();

	always @(posedge clk or negedge arst_n) begin
		longint ua, ub, uc;
		int fa, fb, fc;
		lines_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected result ab=%0d bc=%0d ca=%0d", $time,
						line_ab, line_bc, line_ca);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_lines.pop_front();
					if (want.ab !== line_ab || want.bc !== line_bc || want.ca !== line_ca) begin
						$display("%0t: mismatch expected ab=%0d bc=%0d ca=%0d, got ab=%0d bc=%0d ca=%0d",
							$time, want.ab, want.bc, want.ca, line_ab, line_bc, line_ca);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				ua = volt_val(phase_a_raw);
				ub = volt_val(phase_b_raw);
				uc = volt_val(phase_c_raw);
				fa = angle_val(angle_a_raw);
				fb = angle_val(angle_b_raw);
				fc = angle_val(angle_c_raw);
				want.ab = cosine_law(ua, ub, fold_gap(fa, fb));
				want.bc = cosine_law(ub, uc, fold_gap(fb, fc));
				want.ca = cosine_law(uc, ua, fold_gap(fc, fa));
				expected_lines.push_back(want);
			end
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: line voltage block stimulus and verdict
// Directed corner items, then random meter readings with random gaps; the
// checker predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [31:0]        phase_a_raw, phase_b_raw, phase_c_raw;
	logic signed [15:0] angle_a_raw, angle_b_raw, angle_c_raw;
	logic               done;
	logic [16:0]        line_ab, line_bc, line_ca;
	int                 fail_count;
	int                 pending;
	int                 items_sent;

	line_voltage_from_phases u_dut (.*);
	line_voltage_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Global watchdog: ~1200 items with their idle gaps and the drain take far less time than this.
	initial begin
		#2_000_000;
		$display("[line_voltage_from_phases] ERROR");
		$finish;
	end

	// Voltage words: weighted toward the real range, with saturation and all-ones.
	function automatic logic [31:0] rand_volt();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return $urandom();
			2: return 65535 + $urandom_range(0, 3);
			3: return $urandom_range(0, 15);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Angles: mostly near a balanced three-phase set, sometimes arbitrary.
	function automatic logic [15:0] rand_angle(input int base);
		case ($urandom_range(0, 7))
			0: return 16'hFFFF;
			1: return $urandom();
			2: return 16'(base + $urandom_range(0, 3600) - 1800);
			default: return 16'(base + $urandom_range(0, 40) - 20);
		endcase
	endfunction

	// Drive one item and hold start until accepted; start stays up for a
	// following back-to-back item.
	task automatic send_item(input logic [31:0] va, vb, vc, input logic [15:0] aa, ab, ac);
		phase_a_raw <= va;
		phase_b_raw <= vb;
		phase_c_raw <= vc;
		angle_a_raw <= aa;
		angle_b_raw <= ab;
		angle_c_raw <= ac;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop start only when an idle gap follows.
	task automatic idle_gap(input bit allow);
		int n;
		n = allow ? $urandom_range(0, 18) : 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		int burst;
		start <= 1'b0;
		phase_a_raw <= '0; phase_b_raw <= '0; phase_c_raw <= '0;
		angle_a_raw <= '0; angle_b_raw <= '0; angle_c_raw <= '0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, all-ones words, saturation, gap folding and wrap
		send_item(0, 0, 0, 0, 0, 0);
		send_item(2300, 2300, 2300, 0, 16'd1200, -16'sd1200);
		send_item(65535, 65535, 65535, 0, 16'd1800, 16'd900);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 65536, 16'hFFFF, 16'h7FFF, 16'h8000);
		send_item(32'hFFFF_FFFE, 1, 65535, 16'sd1801, -16'sd1800, 16'sd3600);
		send_item(65535, 65535, 1, 16'h7FFF, 16'h8000, 0);
		send_item(65535, 65535, 65535, 0, 0, 0);
		send_item(65535, 65535, 65535, 16'sd900, -16'sd900, 16'sd2700);
		send_item(1, 65535, 32'h8000_0000, 16'sd1799, -16'sd1, 16'sd5400);
		send_item(32'h5555_5555, 32'hAAAA_AAAA, 12345, 16'h5555, 16'hAAAA, 16'h0001);
		send_item(100, 200, 300, 16'sd3599, 16'sd0, -16'sd3599);
		send_item(2300, 2310, 2290, 16'sd1, 16'sd1201, 16'sd2401);
		start <= 1'b0;

		// Pause until the pipeline has drained completely
		while (pending != 0)
			@(posedge clk);

		// Random part: bursts of back-to-back items alternate with gapped stretches
		for (int i = 0; i < 1150; i++) begin
			int base;
			if (i % 100 == 0)
				burst = $urandom_range(0, 1);
			base = $urandom_range(0, 3600) - 1800;
			send_item(rand_volt(), rand_volt(), rand_volt(), rand_angle(base),
				rand_angle(base - 1200), rand_angle(base + 1200));
			idle_gap(burst == 0);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d items: corner voltages and angles, then random readings.", items_sent);
		if (fail_count == 0)
			$display("[line_voltage_from_phases] OK");
		else
			$display("[line_voltage_from_phases] ERROR");
		$finish;
	end

endmodule
